// ===== rtl/utf8_stream_validator_core_defines.svh =====
// Assertion macros shared by the validator RTL.
// The clock is clk and the reset is rst_n, active low, in every user.
`ifndef UTF8_STREAM_VALIDATOR_CORE_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define USV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define USV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define USV_ASSERT_SAME(label, ante, cons, msg)
`define USV_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/usv_pkg.sv =====
`timescale 1ns / 1ps
package usv_pkg;

  localparam int ACC_W = 21;

  localparam logic [7:0] NUL_BYTE     = 8'h00;
  localparam logic [7:0] ASCII_MAX    = 8'h7f;
  localparam logic [7:0] LEAD2_MIN    = 8'hc2;
  localparam logic [7:0] LEAD2_MAX    = 8'hdf;
  localparam logic [7:0] LEAD3_MIN    = 8'he0;
  localparam logic [7:0] LEAD3_MAX    = 8'hef;
  localparam logic [7:0] LEAD4_MIN    = 8'hf0;
  localparam logic [7:0] LEAD4_MAX    = 8'hf4;
  localparam logic [7:0] CONT_MASK    = 8'hc0;
  localparam logic [7:0] CONT_TAG     = 8'h80;

  localparam logic [ACC_W-1:0] MIN_CP_3B = 21'h000800;
  localparam logic [ACC_W-1:0] MIN_CP_4B = 21'h010000;
  localparam logic [ACC_W-1:0] SURR_LO   = 21'h00d800;
  localparam logic [ACC_W-1:0] SURR_HI   = 21'h00dfff;
  localparam logic [ACC_W-1:0] CP_MAX    = 21'h10ffff;

  // Continuation bytes expected by a lead byte.
  localparam logic [1:0] SEQ_NONE = 2'd0;
  localparam logic [1:0] SEQ_2B   = 2'd1;
  localparam logic [1:0] SEQ_3B   = 2'd2;
  localparam logic [1:0] SEQ_4B   = 2'd3;

  // Item leaving the input register towards the decoder.
  typedef struct packed {
    logic       go;
    logic [7:0] byte_value;
    logic       last;
  } step_t;

  // Verdict handed from the decoder to the result register.
  typedef struct packed {
    logic load;
    logic valid_res;
  } verdict_t;

endpackage

// ===== rtl/usv_in_stage.sv =====
`timescale 1ns / 1ps
module usv_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte_value,
  input  logic          in_last_byte,
  input  logic          out_free,
  output usv_pkg::step_t step
);
  import usv_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_go;
  logic       in_take;

  // A non-final byte never needs the result register, so it always moves on.
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_byte_value;
      s1_last_r <= in_last_byte;
    end
  end

  assign step.go         = s1_go;
  assign step.byte_value = s1_byte_r;
  assign step.last       = s1_last_r;

endmodule

// ===== rtl/usv_decoder.sv =====
`timescale 1ns / 1ps
`include "utf8_stream_validator_core_defines.svh"
module usv_decoder (
  input  logic              clk,
  input  logic              rst_n,
  input  usv_pkg::step_t    step,
  output usv_pkg::verdict_t verdict
);
  import usv_pkg::*;

  logic [1:0]       pend_r, pend_nxt;
  logic [1:0]       len_r, len_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             fail_r, fail_nxt;
  logic [ACC_W-1:0] acc_shift;
  logic [7:0]       b;
  logic             cp_bad;

  assign b         = step.byte_value;
  assign acc_shift = {acc_r[ACC_W-7:0], b[5:0]};

  // Checks applied once the last continuation byte has been folded in.
  assign cp_bad = (len_r == SEQ_3B && acc_shift < MIN_CP_3B) ||
                  (len_r == SEQ_4B && acc_shift < MIN_CP_4B) ||
                  (acc_shift >= SURR_LO && acc_shift <= SURR_HI) ||
                  (acc_shift > CP_MAX);

  always_comb begin
    pend_nxt = pend_r;
    len_nxt  = len_r;
    acc_nxt  = acc_r;
    fail_nxt = fail_r;
    if (!fail_r) begin
      if (pend_r == SEQ_NONE) begin
        priority if (b <= ASCII_MAX) begin
          if (b == NUL_BYTE) begin
            fail_nxt = 1'b1;
          end
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
          acc_nxt  = ACC_W'(b[4:0]);
          len_nxt  = SEQ_2B;
          pend_nxt = SEQ_2B;
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
          acc_nxt  = ACC_W'(b[3:0]);
          len_nxt  = SEQ_3B;
          pend_nxt = SEQ_3B;
        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
          acc_nxt  = ACC_W'(b[2:0]);
          len_nxt  = SEQ_4B;
          pend_nxt = SEQ_4B;
        end else begin
          fail_nxt = 1'b1;
        end
      end else if ((b & CONT_MASK) != CONT_TAG) begin
        fail_nxt = 1'b1;
      end else begin
        acc_nxt  = acc_shift;
        pend_nxt = pend_r - 2'd1;
        if (pend_r == SEQ_2B && cp_bad) begin
          fail_nxt = 1'b1;
        end
      end
    end
  end

  assign verdict.load      = step.go && step.last;
  assign verdict.valid_res = !fail_nxt && (pend_nxt == SEQ_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= SEQ_NONE;
      len_r  <= SEQ_NONE;
      acc_r  <= '0;
      fail_r <= 1'b0;
    end else if (step.go) begin
      if (step.last) begin
        pend_r <= SEQ_NONE;
        len_r  <= SEQ_NONE;
        acc_r  <= '0;
        fail_r <= 1'b0;
      end else begin
        pend_r <= pend_nxt;
        len_r  <= len_nxt;
        acc_r  <= acc_nxt;
        fail_r <= fail_nxt;
      end
    end
  end

  `USV_ASSERT_NEXT(a_clear_after_last, step.go && step.last, pend_r == SEQ_NONE && !fail_r && len_r == SEQ_NONE, "decoder state not cleared after final byte")
  `USV_ASSERT_SAME(a_pend_within_len, 1'b1, pend_r <= len_r, "more continuation bytes pending than the sequence holds")

endmodule

// ===== rtl/usv_out_stage.sv =====
`timescale 1ns / 1ps
module usv_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  usv_pkg::verdict_t verdict,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_valid_res
);
  import usv_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic out_res_r;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (verdict.load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (verdict.load) begin
      out_res_r <= verdict.valid_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = out_res_r;

endmodule

// ===== rtl/utf8_stream_validator_core.sv =====
`timescale 1ns / 1ps
// UTF-8 stream validator. A string is presented one byte per item on the input
// channel, with in_last_byte set on its final byte; exactly one result item
// follows each final byte, and out_valid_res is 1 only when the whole string is
// well-formed UTF-8 with no NUL byte. Bad lead or continuation bytes, overlong
// three- and four-byte forms, surrogates, code points above 10FFFF and a
// sequence cut short by the end of the string all give 0. Bytes after a
// failure are still consumed but ignored, and all state clears after each final
// byte, so strings may follow each other without a gap. The block takes one
// byte every cycle while not stalled: the input register feeds a combinational
// decode of the byte against a small state (bytes still expected, sequence
// length, code point being assembled, failure flag), and the verdict of a final
// byte is loaded into the result register as the byte leaves the input
// register, which raises out_valid. The input side stalls only when a final
// byte waits in the input register while the result register still holds an
// untaken result; non-final bytes never wait on the output.
`include "utf8_stream_validator_core_defines.svh"
module utf8_stream_validator_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_value,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_valid_res
);
  import usv_pkg::*;

  step_t    step;
  verdict_t verdict;
  logic     out_free;

  // Input register and the stall that protects it.
  usv_in_stage u_in_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte_value (in_byte_value),
    .in_last_byte  (in_last_byte),
    .out_free      (out_free),
    .step          (step)
  );

  // Per-byte decode and the running state of the current string.
  usv_decoder u_decoder (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .verdict (verdict)
  );

  // Result register: holds a verdict until the far side takes it.
  usv_out_stage u_out_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .verdict       (verdict),
    .out_free      (out_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res)
  );

  // A result only ever appears as a consequence of a final byte being decoded.
  `USV_ASSERT_SAME(a_result_from_last, $rose(out_valid), $past(verdict.load), "result item appeared without a final byte")
  // With the result register empty nothing can hold up the input register.
  `USV_ASSERT_SAME(a_no_stall_when_empty, !out_valid, !in_stall, "input stalled while the result register is empty")

endmodule
